FILE: rtl/core/bira_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bira_pkg
// Shared widths, codes and helpers of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bira_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;    // bit index inside a bitmap word
    localparam int ID_W      = 15;   // identifier field width
    localparam int CURSOR_W  = 16;   // search cursor width
    localparam int LEN_W     = 11;   // map length register width
    localparam int ID_WORDS  = 1024; // words that a 15-bit identifier can reach

    localparam logic [CURSOR_W-1:0] CURSOR_RESET = 16'd1;

    // Item kinds carried on tuser
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef logic [WORD_BITS-1:0] map_word_t;

    // Priority encoder: index of the lowest set bit, 31 when the word is empty
    function automatic logic [BIT_W-1:0] lowest_bit(input map_word_t w);
        logic [BIT_W-1:0] b;
        b = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/bitmap_id_reuse_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_reuse_allocator
// Next-fit allocator of recycled identifiers over a bitmap of free ids.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready: s_tuser selects get (0) or put (1),
// s_tdata carries the identifier to put back. Every item yields one result
// item on m_tvalid/m_tready: the granted identifier for a get, 0 for a put or
// when no identifier is free. The map length register (cfg_we/cfg_wdata) is
// to be written only while the block is idle; the block does not enforce this.
// Zero disables the allocator. The bitmap lives in a single-port-write,
// single-port-read memory with registered read data; one word is read per
// cycle. A put reads its word, writes it back with the bit set, then loads
// the result; a put outside the map, or a get that finds the cursor past the
// map, goes straight to the result load. Otherwise a get reads words one after
// another from the cursor word until a free bit or the map end, so the memory
// read port sets the rate. One item is in work at a time; s_tready is low
// until the result is loaded into the output register and rises the cycle
// after, so the next item is accepted no earlier than that. A result waiting
// on a stalled receiver holds the block only when the next result is ready.
// After reset a clearing pass writes zero to every bitmap word, one word per
// cycle; no item is accepted meanwhile.
// ----------------------------------------------------------------------------
module bitmap_id_reuse_allocator #(
    parameter int MAP_WORDS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: map_words
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [14:0] ident, [15] zero
    input  logic        s_tuser,   // [0] mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [14:0] granted_ident, [15] zero
);

    // only words reachable by an identifier need storage
    localparam int MemWords = (MAP_WORDS < bira_pkg::ID_WORDS) ? MAP_WORDS
                                                               : bira_pkg::ID_WORDS;
    localparam int AW       = (MemWords > 1) ? $clog2(MemWords) : 1;
    localparam int LenCap   = (MAP_WORDS > 2047) ? 2047 : MAP_WORDS;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_PUT  = 3'd2;
    localparam logic [2:0] ST_GET  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [bira_pkg::LEN_W-1:0] MEM_WORDS_L = bira_pkg::LEN_W'(MemWords);
    localparam logic [bira_pkg::LEN_W-1:0] LEN_CAP_L   = bira_pkg::LEN_W'(LenCap);

    // bitmap memory
    bira_pkg::map_word_t mem [MemWords];
    bira_pkg::map_word_t rd_data_reg;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    bira_pkg::map_word_t mem_wdata;

    logic [2:0]                       state_reg, state_next;
    logic [AW-1:0]                    clr_reg, clr_next;
    logic [bira_pkg::LEN_W-1:0]       map_words_reg;
    logic [bira_pkg::CURSOR_W-1:0]    cursor_reg, cursor_next;
    logic [bira_pkg::LEN_W-1:0]       scan_reg, scan_next;
    logic [bira_pkg::ID_W-1:0]        ident_reg, ident_next;
    logic                             mode_reg, mode_next;
    logic [bira_pkg::ID_W-1:0]        result_reg, result_next;
    logic                             m_valid_reg, m_valid_next;
    logic [bira_pkg::ID_W-1:0]        m_data_reg, m_data_next;

    logic [bira_pkg::LEN_W-1:0]       len;
    logic [bira_pkg::LEN_W-1:0]       cur_word;
    logic [bira_pkg::LEN_W-1:0]       scan_inc;
    logic [bira_pkg::LEN_W-1:0]       put_word;
    bira_pkg::map_word_t              get_word;
    logic [bira_pkg::BIT_W-1:0]       get_bit;
    logic [bira_pkg::CURSOR_W-1:0]    get_id;
    logic [bira_pkg::CURSOR_W-1:0]    end_cursor;
    logic                             out_free;
    logic                             s_accept;

    assign len        = (map_words_reg > LEN_CAP_L) ? LEN_CAP_L : map_words_reg;
    assign cur_word   = cursor_reg[bira_pkg::CURSOR_W-1:bira_pkg::BIT_W];
    assign scan_inc   = scan_reg + 1'b1;
    assign put_word   = {1'b0, ident_reg[bira_pkg::ID_W-1:bira_pkg::BIT_W]};
    assign end_cursor = {len, {bira_pkg::BIT_W{1'b0}}};
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;

    // mask bits below the cursor in the first scanned word
    always_comb begin
        get_word = rd_data_reg;
        if (scan_reg == cur_word) begin
            get_word = rd_data_reg &
                       ~((bira_pkg::map_word_t'(1) << cursor_reg[bira_pkg::BIT_W-1:0])
                         - bira_pkg::map_word_t'(1));
        end
    end
    assign get_bit = bira_pkg::lowest_bit(get_word);
    assign get_id  = {scan_reg, get_bit};

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cursor_next  = cursor_reg;
        scan_next    = scan_reg;
        ident_next   = ident_reg;
        mode_next    = mode_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_re       = 1'b0;
        mem_raddr    = scan_reg[AW-1:0];
        mem_we       = 1'b0;
        mem_waddr    = scan_reg[AW-1:0];
        mem_wdata    = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MemWords - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    ident_next  = s_tdata[bira_pkg::ID_W-1:0];
                    mode_next   = s_tuser;
                    result_next = '0;
                    if (s_tuser == bira_pkg::MODE_PUT) begin
                        if ({1'b0, s_tdata[bira_pkg::ID_W-1:bira_pkg::BIT_W]} < len) begin
                            mem_re     = 1'b1;
                            mem_raddr  = s_tdata[bira_pkg::BIT_W +: AW];
                            state_next = ST_PUT;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else if (cur_word >= len) begin
                        // cursor past map: nothing changes
                        state_next = ST_DONE;
                    end else if (cur_word >= MEM_WORDS_L) begin
                        // no stored word left to scan
                        cursor_next = end_cursor;
                        state_next  = ST_DONE;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = cur_word[AW-1:0];
                        scan_next  = cur_word;
                        state_next = ST_GET;
                    end
                end
            end
            ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = put_word[AW-1:0];
                mem_wdata = rd_data_reg |
                            (bira_pkg::map_word_t'(1) << ident_reg[bira_pkg::BIT_W-1:0]);
                if (cursor_reg > {1'b0, ident_reg}) begin
                    cursor_next = {1'b0, ident_reg};
                end
                state_next = ST_DONE;
            end
            ST_GET: begin
                if (get_word != '0) begin
                    mem_we      = 1'b1;
                    mem_waddr   = scan_reg[AW-1:0];
                    mem_wdata   = rd_data_reg & ~(bira_pkg::map_word_t'(1) << get_bit);
                    cursor_next = get_id + 1'b1;
                    result_next = get_id[bira_pkg::ID_W-1:0];
                    state_next  = ST_DONE;
                end else if (scan_inc >= len || scan_inc >= MEM_WORDS_L) begin
                    cursor_next = end_cursor;
                    state_next  = ST_DONE;
                end else begin
                    // advance to the next word
                    mem_re     = 1'b1;
                    mem_raddr  = scan_inc[AW-1:0];
                    scan_next  = scan_inc;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            map_words_reg <= '0;
            cursor_reg    <= bira_pkg::CURSOR_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                map_words_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        ident_reg  <= ident_next;
        mode_reg   <= mode_next;
        result_reg <= result_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

`ifndef ASSERT_OFF
    // one item at a time: never ready right after an acceptance
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted while previous item in work");

    // a put never produces a nonzero result
    a_put_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && mode_reg == bira_pkg::MODE_PUT) |-> (result_reg == '0))
        else $error("put produced nonzero result");

    // the bitmap is never written while waiting for an item or for the output
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !mem_we)
        else $error("bitmap write outside clear or update step");

    // a new result is loaded only into a free output slot
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("pending result overwritten");
`endif

endmodule

FILE: tb/bitmap_id_reuse_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_reuse_allocator_tb
// Drives get and put items into the identifier allocator under bursty input
// and a stalling receiver, predicts every granted identifier from an own copy
// of the free map, the search cursor and the map length, and checks each
// result item in order. The map length is changed between phases, its
// extremes included.
// ----------------------------------------------------------------------------
module bitmap_id_reuse_allocator_tb;

    import bira_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;

    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] ident;
    } alloc_req_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = MODE_GET;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    // predicted block state
    map_word_t           free_map [ID_WORDS];
    logic [CURSOR_W-1:0] cursor;
    logic [LEN_W-1:0]    map_len;

    alloc_req_t      req_q[$];
    logic [ID_W-1:0] grant_q[$];
    alloc_req_t      cur_item;
    logic [ID_W-1:0] exp_id;
    int              burst_left = 0;
    int              gap_left   = 0;
    int              err_cnt    = 0;
    int              cycle_cnt  = 0;
    int unsigned     stall_cnt  = 0;
    int unsigned     stall_mode = 0;

    bitmap_id_reuse_allocator #(
        .MAP_WORDS (ID_WORDS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned used_words();
        return (map_len > ID_WORDS) ? ID_WORDS : int'(map_len);
    endfunction

    // Scan from the cursor for the lowest free id, claim it and advance.
    function automatic logic [ID_W-1:0] next_free_id();
        int unsigned n;
        int unsigned w;
        int unsigned b;
        map_word_t   word;
        n = used_words();
        if (n == 0 || (cursor >> 5) >= n) begin
            return '0;
        end
        for (w = cursor >> 5; w < n; w++) begin
            word = free_map[w];
            if (w == (cursor >> 5)) begin
                word &= ~((32'd1 << cursor[4:0]) - 32'd1);
            end
            if (word != '0) begin
                b = 0;
                while (!word[b]) begin
                    b++;
                end
                free_map[w][b] = 1'b0;
                cursor = CURSOR_W'((w << 5) | b) + 16'd1;
                return ID_W'((w << 5) | b);
            end
        end
        cursor = CURSOR_W'(n << 5);
        return '0;
    endfunction

    function automatic void release_id(input logic [ID_W-1:0] id);
        int unsigned n;
        n = used_words();
        if (n == 0 || int'(id[14:5]) >= n) begin
            return;
        end
        free_map[id[14:5]][id[4:0]] = 1'b1;
        if (cursor > id) begin
            cursor = CURSOR_W'(id);
        end
    endfunction

    // Sender: bursts of random length, random gaps in between.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (cur_item.mode == MODE_GET) begin
                    grant_q.push_back(next_free_id());
                end else begin
                    release_id(cur_item.ident);
                    grant_q.push_back('0);
                end
            end
            if (gap_left > 0 || req_q.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                s_tvalid <= 1'b0;
            end else begin
                cur_item = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, cur_item.ident};
                s_tuser  <= cur_item.mode;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // Receiver: switch stall pattern whenever the low six bits of the stall counter wrap to zero.
    always @(posedge aclk) begin
        stall_cnt = stall_cnt + 1;
        if (stall_cnt[5:0] == 6'd0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= (stall_cnt[2:1] == 2'd0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                $display("%0t: result item with none pending: expected none, got %h",
                         $time, m_tdata);
                err_cnt++;
            end else begin
                exp_id = grant_q.pop_front();
                if (m_tdata !== {1'b0, exp_id}) begin
                    $display("%0t: granted_ident mismatch: expected %h, got %h",
                             $time, {1'b0, exp_id}, m_tdata);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_map_words(input logic [LEN_W-1:0] len);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        map_len   = len;
    endtask

    task automatic send(input logic mode, input logic [ID_W-1:0] id);
        alloc_req_t r;
        r.mode  = mode;
        r.ident = id;
        req_q.push_back(r);
    endtask

    // Wait until every item is out and answered, then let the block settle.
    task automatic drain();
        while (req_q.size() != 0 || s_tvalid || grant_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_phase(input logic [LEN_W-1:0] len, input int count);
        int unsigned span;
        logic        mode;
        logic [ID_W-1:0] id;
        set_map_words(len);
        span = ((len > ID_WORDS) ? ID_WORDS : int'(len)) * WORD_BITS;
        for (int i = 0; i < count; i++) begin
            mode = ($urandom_range(0, 99) < 55) ? MODE_PUT : MODE_GET;
            // mostly ids inside the map, some anywhere
            if (span != 0 && $urandom_range(0, 9) != 0) begin
                id = ID_W'($urandom_range(0, span - 1));
            end else begin
                id = ID_W'($urandom);
            end
            send(mode, id);
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < ID_WORDS; i++) begin
            free_map[i] = '0;
        end
        cursor  = CURSOR_RESET;
        map_len = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // disabled block: puts dropped, gets answer zero
        set_map_words(11'd0);
        send(MODE_PUT, 15'd7);
        send(MODE_GET, 15'd0);
        send(MODE_PUT, 15'd0);
        send(MODE_GET, 15'h7FFF);
        drain();

        // identifier zero, word edges, puts beyond the map, cursor past the map
        set_map_words(11'd2);
        send(MODE_PUT, 15'd0);
        send(MODE_PUT, 15'd31);
        send(MODE_PUT, 15'd32);
        send(MODE_PUT, 15'd63);
        send(MODE_PUT, 15'd64);
        send(MODE_PUT, 15'h7FFF);
        repeat (5) send(MODE_GET, 15'd0);
        drain();

        // oversized length acts as full map; empty scan runs to the end
        set_map_words(11'h7FF);
        send(MODE_PUT, 15'h7FFF);
        send(MODE_GET, 15'd0);
        send(MODE_GET, 15'd0);
        send(MODE_PUT, 15'd5);
        send(MODE_GET, 15'd0);
        send(MODE_GET, 15'd0);
        drain();

        random_phase(11'd1, 100);
        random_phase(11'd3, 100);
        random_phase(11'd1024, 40);
        random_phase(11'd0, 20);
        random_phase(11'd2, 100);
        random_phase(11'd8, 100);
        random_phase(11'h7FF, 40);
        random_phase(11'd5, 100);
        random_phase(11'd1, 100);
        random_phase(11'd32, 100);

        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
